FILE: hdl/rotated_sorted_array_search_unit_assert.svh
// ----------------------------------------------------------------------------
// rotated sorted array search unit - assertion macros
// shared concurrent assertion forms, clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_UNIT_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define RSAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rsas_pkg.sv
// ----------------------------------------------------------------------------
// rsas_pkg
// shared types and constants of the rotated sorted array search unit
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = CNT_W + 1;
    localparam int POS_W       = 10;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [IDX_W-1:0]      idx_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        logic  op;
        data_t value;
        logic  last;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } out_t;

    // load request into the element store
    typedef struct packed {
        logic  en;
        data_t value;
        logic  last;
    } ld_req_t;

    // read request into the element store
    typedef struct packed {
        logic  en;
        addr_t addr;
    } rd_req_t;

    // shared comparator result
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_t;

endpackage

FILE: hdl/rsas_cmp.sv
// ----------------------------------------------------------------------------
// rsas_cmp
// shared signed magnitude comparator used by every search step
// ----------------------------------------------------------------------------
module rsas_cmp
    import rsas_pkg::*;
(
    input  data_t a,
    input  data_t b,
    output cmp_t  res
);

    always_comb begin
        res.lt = (a < b);
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

FILE: hdl/rsas_store.sv
// ----------------------------------------------------------------------------
// rsas_store
// element memory with fill count and array-closed flag, one read port
// ----------------------------------------------------------------------------
module rsas_store
    import rsas_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  ld_req_t ld,
    input  rd_req_t rd,
    output data_t   rd_data,
    output cnt_t    count
);

    data_t mem [MAX_ENTRIES];
    data_t rd_data_reg;
    cnt_t  count_reg,  count_next;
    logic  closed_reg, closed_next;
    cnt_t  base;
    logic  wr_en;

    // a load into a closed array restarts it
    assign base  = closed_reg ? '0 : count_reg;
    assign wr_en = ld.en && (base < CNT_W'(MAX_ENTRIES));

    always_comb begin
        count_next  = count_reg;
        closed_next = closed_reg;
        if (ld.en) begin
            count_next  = wr_en ? base + cnt_t'(1) : base;
            closed_next = ld.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            closed_reg <= 1'b1;
        end else begin
            count_reg  <= count_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[base[ADDR_W-1:0]] <= ld.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

FILE: hdl/rotated_sorted_array_search_unit.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_unit
// search for a key in a stored ascending array that was rotated
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one transfer per item; op selects load (append value, last
//   closes the array) or search (value is the key). a load after a closed
//   array starts a new one; loads past capacity are dropped.
//   m_ channel: one transfer per search with found and position; loads give
//   no result.
// sequence:
//   a load is taken in the idle state and s_ready stays high.
//   a search first walks a binary search for the rotation point (states RHI,
//   RLO, RM1 if mid is above zero, RMID and RSTEP per halving step), then
//   binary searches the left and right runs (SCHK and SCMP per step). every
//   memory read uses the single read port and every element compare the one
//   shared comparator. s_ready is low while a search runs.
// reset: aresetn synchronous, active low; empties the array and marks it
//   closed; memory contents are not cleared, and none is needed.
// stall: the result sits in an output register; loads keep flowing while it
//   waits, and a finished search holds until the register frees up.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_unit
    import rsas_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIRST = 10'b0000000010,
        S_RHI   = 10'b0000000100,
        S_RLO   = 10'b0000001000,
        S_RM1   = 10'b0000010000,
        S_RMID  = 10'b0000100000,
        S_RSTEP = 10'b0001000000,
        S_SCHK  = 10'b0010000000,
        S_SCMP  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    localparam idx_t IDX_ONE  = idx_t'(1);
    localparam idx_t IDX_ZERO = idx_t'(0);

    state_t state_reg, state_next;
    idx_t   lo_reg, lo_next;
    idx_t   hi_reg, hi_next;
    idx_t   mid_reg, mid_next;
    idx_t   k_reg, k_next;
    logic   right_reg, right_next;
    data_t  key_reg, key_next;
    data_t  first_reg, first_next;
    data_t  hv_reg, hv_next;
    data_t  pv_reg, pv_next;
    data_t  mv_reg, mv_next;
    logic   found_reg, found_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic   m_valid_reg, m_valid_next;
    out_t   m_data_reg, m_data_next;

    ld_req_t ld;
    rd_req_t rd;
    data_t   rd_data;
    cnt_t    count;
    idx_t    n_last;
    data_t   cmp_a, cmp_b;
    cmp_t    cmp;
    idx_t    mid_calc;
    idx_t    step_lo, step_hi;
    logic    out_free;

    // element memory with fill count
    rsas_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld      (ld),
        .rd      (rd),
        .rd_data (rd_data),
        .count   (count)
    );

    // the one comparator every step goes through
    rsas_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign n_last   = idx_t'({1'b0, count}) - IDX_ONE;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);

    // loads complete in the idle cycle they are accepted
    always_comb begin
        ld.en    = s_valid && s_ready && (s_data.op == OP_LOAD);
        ld.value = s_data.value;
        ld.last  = s_data.last;
    end

    // rotation step: keep the right half when mid is still in the upper run
    always_comb begin
        if (!cmp.lt) begin
            step_lo = mid_reg + IDX_ONE;
            step_hi = hi_reg;
        end else begin
            step_lo = lo_reg;
            step_hi = mid_reg - IDX_ONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        k_next     = k_reg;
        right_next = right_reg;
        key_next   = key_reg;
        first_next = first_reg;
        hv_next    = hv_reg;
        pv_next    = pv_reg;
        mv_next    = mv_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        rd.en      = 1'b0;
        rd.addr    = '0;
        cmp_a      = first_reg;
        cmp_b      = first_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && (s_data.op == OP_SEARCH)) begin
                    key_next = s_data.value;
                    if (count == '0) begin
                        // empty array never matches
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        lo_next    = IDX_ZERO;
                        hi_next    = n_last;
                        rd.en      = 1'b1;
                        rd.addr    = '0;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                first_next = rd_data;
                if (lo_reg >= hi_reg) begin
                    // single element: no rotation
                    k_next     = lo_reg;
                    lo_next    = IDX_ZERO;
                    hi_next    = lo_reg - IDX_ONE;
                    right_next = 1'b0;
                    state_next = S_SCHK;
                end else begin
                    rd.en      = 1'b1;
                    rd.addr    = hi_reg[ADDR_W-1:0];
                    state_next = S_RHI;
                end
            end
            S_RHI: begin
                hv_next    = rd_data;
                rd.en      = 1'b1;
                rd.addr    = lo_reg[ADDR_W-1:0];
                state_next = S_RLO;
            end
            S_RLO: begin
                cmp_a = hv_reg;
                cmp_b = rd_data;
                if (!cmp.lt) begin
                    // window already ascending, lo is the minimum
                    k_next     = lo_reg;
                    lo_next    = IDX_ZERO;
                    hi_next    = lo_reg - IDX_ONE;
                    right_next = 1'b0;
                    state_next = S_SCHK;
                end else begin
                    mid_next = mid_calc;
                    rd.en    = 1'b1;
                    if (mid_calc > IDX_ZERO) begin
                        rd.addr    = addr_t'(mid_calc - IDX_ONE);
                        state_next = S_RM1;
                    end else begin
                        rd.addr    = mid_calc[ADDR_W-1:0];
                        state_next = S_RMID;
                    end
                end
            end
            S_RM1: begin
                pv_next    = rd_data;
                rd.en      = 1'b1;
                rd.addr    = mid_reg[ADDR_W-1:0];
                state_next = S_RMID;
            end
            S_RMID: begin
                mv_next = rd_data;
                cmp_a   = pv_reg;
                cmp_b   = rd_data;
                if ((mid_reg > IDX_ZERO) && cmp.gt) begin
                    // descent right before mid marks the rotation point
                    k_next     = mid_reg;
                    lo_next    = IDX_ZERO;
                    hi_next    = mid_reg - IDX_ONE;
                    right_next = 1'b0;
                    state_next = S_SCHK;
                end else begin
                    state_next = S_RSTEP;
                end
            end
            S_RSTEP: begin
                cmp_a = mv_reg;
                cmp_b = first_reg;
                if (step_lo >= step_hi) begin
                    k_next     = step_lo;
                    lo_next    = IDX_ZERO;
                    hi_next    = step_lo - IDX_ONE;
                    right_next = 1'b0;
                    state_next = S_SCHK;
                end else begin
                    lo_next    = step_lo;
                    hi_next    = step_hi;
                    rd.en      = 1'b1;
                    rd.addr    = step_hi[ADDR_W-1:0];
                    state_next = S_RHI;
                end
            end
            S_SCHK: begin
                if (lo_reg <= hi_reg) begin
                    mid_next   = mid_calc;
                    rd.en      = 1'b1;
                    rd.addr    = mid_calc[ADDR_W-1:0];
                    state_next = S_SCMP;
                end else if (!right_reg) begin
                    // left run exhausted, try the right run
                    lo_next    = k_reg;
                    hi_next    = n_last;
                    right_next = 1'b1;
                end else begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_SCMP: begin
                cmp_a      = rd_data;
                cmp_b      = key_reg;
                state_next = S_SCHK;
                if (cmp.gt) begin
                    hi_next = mid_reg - IDX_ONE;
                end else if (cmp.lt) begin
                    lo_next = mid_reg + IDX_ONE;
                end else begin
                    found_next = 1'b1;
                    pos_next   = mid_reg[POS_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, loaded once the previous result has gone
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_valid_next         = 1'b1;
            m_data_next.found    = found_reg;
            m_data_next.position = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        k_reg      <= k_next;
        right_reg  <= right_next;
        key_reg    <= key_next;
        first_reg  <= first_next;
        hv_reg     <= hv_next;
        pv_reg     <= pv_next;
        mv_reg     <= mv_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/rsas_checker.sv
// ----------------------------------------------------------------------------
// rsas_checker
// port-level checks on the rotated sorted array search unit
// ----------------------------------------------------------------------------
`include "rotated_sorted_array_search_unit_assert.svh"

module rsas_checker
    import rsas_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result holds
    `RSAS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // a miss always reports position zero
    `RSAS_ASSERT_NOW(a_miss_pos, m_valid && !m_data.found, m_data.position == '0, "miss with nonzero position")

    // a search transfer keeps the block busy
    `RSAS_ASSERT_NEXT(a_search_busy, s_valid && s_ready && (s_data.op == OP_SEARCH), !s_ready, "ready right after a search")

    // a load transfer never raises a result
    `RSAS_ASSERT_NEXT(a_load_silent, s_valid && s_ready && (s_data.op == OP_LOAD), !$rose(m_valid), "result raised by a load")

endmodule

bind rotated_sorted_array_search_unit rsas_checker u_rsas_checker (.*);
